[src/i2cdfw_pkg.sv]
// shared types and constants for the i2c display frame writer
`default_nettype none

package i2cdfw_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMMAND_CONTROL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_CONTROL    = 2'd2;

  localparam logic [BYTE_W-1:0] RST_DEVICE_ADDRESS  = 8'h78;
  localparam logic [BYTE_W-1:0] RST_COMMAND_CONTROL = 8'h00;
  localparam logic [BYTE_W-1:0] RST_DATA_CONTROL    = 8'h40;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  typedef struct packed {
    logic              op;
    logic              is_data;
    logic [BYTE_W-1:0] write_byte;
  } in_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic busy_res;
    logic frame_done;
    logic rejected;
  } out_t;

  typedef struct packed {
    logic [BYTE_W-1:0] device_address;
    logic [BYTE_W-1:0] command_control;
    logic [BYTE_W-1:0] data_control;
  } cfg_t;

endpackage

`default_nettype wire

[src/i2cdfw_seq.sv]
// frame sequencer: tick counters, latched request and held line levels
`default_nettype none

module i2cdfw_seq
  import i2cdfw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic step,
  input  wire in_t  item,
  input  wire cfg_t cfg,
  output out_t      res
);

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_BYTE  = 2'd1;
  localparam logic [1:0] PH_STOP  = 2'd2;

  localparam logic [3:0] BIT_ACK   = 4'd8;
  localparam logic [1:0] SUB_LAST  = 2'd2;
  localparam logic [1:0] BYTE_LAST = 2'd2;

  logic              active_r, active_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [1:0]        byte_r, byte_nxt;
  logic [3:0]        bit_r, bit_nxt;
  logic [1:0]        sub_r, sub_nxt;
  logic [BYTE_W-1:0] payload_r, payload_nxt;
  logic              is_data_r, is_data_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_r, sda_nxt;
  logic [BYTE_W-1:0] cur_byte;
  logic              tick_scl, tick_sda;
  logic              last_tick;

  always_comb begin
    unique case (byte_r)
      2'd0:    cur_byte = cfg.device_address;
      2'd1:    cur_byte = is_data_r ? cfg.data_control : cfg.command_control;
      default: cur_byte = payload_r;
    endcase
  end

  // line levels for the current tick
  always_comb begin
    tick_scl  = 1'b1;
    tick_sda  = 1'b1;
    last_tick = 1'b0;
    unique case (phase_r)
      PH_START: begin
        tick_scl = (sub_r != SUB_LAST);
        tick_sda = (sub_r == 2'd0);
      end
      PH_BYTE: begin
        if (bit_r == BIT_ACK) begin
          tick_scl = (sub_r == 2'd0);
          tick_sda = cur_byte[0];
        end else begin
          tick_scl = (sub_r == 2'd1);
          tick_sda = cur_byte[~bit_r[2:0]];
        end
      end
      default: begin
        tick_scl  = 1'b1;
        tick_sda  = (sub_r != 2'd0);
        last_tick = (sub_r != 2'd0);
      end
    endcase
  end

  always_comb begin
    active_nxt  = active_r;
    phase_nxt   = phase_r;
    byte_nxt    = byte_r;
    bit_nxt     = bit_r;
    sub_nxt     = sub_r;
    payload_nxt = payload_r;
    is_data_nxt = is_data_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    res         = '{scl: scl_r, sda: sda_r, busy_res: 1'b0, frame_done: 1'b0,
                    rejected: 1'b0};
    if (item.op == OP_REQUEST) begin
      res.busy_res = 1'b1;
      if (active_r) begin
        res.rejected = 1'b1;
      end else if (step) begin
        active_nxt  = 1'b1;
        payload_nxt = item.write_byte;
        is_data_nxt = item.is_data;
        phase_nxt   = PH_START;
        byte_nxt    = 2'd0;
        bit_nxt     = 4'd0;
        sub_nxt     = 2'd0;
      end
    end else if (active_r) begin
      res.scl        = tick_scl;
      res.sda        = tick_sda;
      res.busy_res   = 1'b1;
      res.frame_done = last_tick;
      if (step) begin
        scl_nxt = tick_scl;
        sda_nxt = tick_sda;
        unique case (phase_r)
          PH_START: begin
            sub_nxt = sub_r + 2'd1;
            if (sub_r == SUB_LAST) begin
              phase_nxt = PH_BYTE;
              byte_nxt  = 2'd0;
              bit_nxt   = 4'd0;
              sub_nxt   = 2'd0;
            end
          end
          PH_BYTE: begin
            sub_nxt = sub_r + 2'd1;
            if (bit_r == BIT_ACK) begin
              if (sub_r != 2'd0) begin
                sub_nxt = 2'd0;
                bit_nxt = 4'd0;
                if (byte_r == BYTE_LAST) begin
                  phase_nxt = PH_STOP;
                end else begin
                  byte_nxt = byte_r + 2'd1;
                end
              end
            end else if (sub_r == SUB_LAST) begin
              sub_nxt = 2'd0;
              bit_nxt = bit_r + 4'd1;
            end
          end
          default: begin
            sub_nxt = sub_r + 2'd1;
            if (last_tick) begin
              active_nxt = 1'b0;
              phase_nxt  = PH_START;
              sub_nxt    = 2'd0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      phase_r   <= PH_START;
      byte_r    <= 2'd0;
      bit_r     <= 4'd0;
      sub_r     <= 2'd0;
      payload_r <= '0;
      is_data_r <= 1'b0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
    end else begin
      active_r  <= active_nxt;
      phase_r   <= phase_nxt;
      byte_r    <= byte_nxt;
      bit_r     <= bit_nxt;
      sub_r     <= sub_nxt;
      payload_r <= payload_nxt;
      is_data_r <= is_data_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
    end
  end

endmodule

`default_nettype wire

[src/i2c_display_frame_writer_top.sv]
// top level of the i2c display frame writer: config registers and result register
//
//   channel  | direction | handshake              | payload
//   in_      | input     | in_valid / in_ready    | in_t  (op, is_data, write_byte)
//   out_     | output    | out_valid / out_ready  | out_t (scl, sda, busy_res, ...)
//   cfg_     | input     | cfg_we, cfg_idx        | cfg_wdata, 8 bits
//
// one result per item taken, in the next cycle; one item per cycle unless stalled
// the sequencer state and the output register are the only storage in the path
// reset (synchronous, rst_n low) idles the sequencer, releases both lines high
// and loads the register defaults
// a new item is taken while the output register is empty or being drained
`default_nettype none

module i2c_display_frame_writer_top
  import i2cdfw_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_t                  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_t                      out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [BYTE_W-1:0]    cfg_wdata
);

  cfg_t cfg_r;
  logic out_valid_r;
  out_t out_data_r;
  out_t res;
  logic accept;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address  <= RST_DEVICE_ADDRESS;
      cfg_r.command_control <= RST_COMMAND_CONTROL;
      cfg_r.data_control    <= RST_DATA_CONTROL;
    end else if (cfg_we) begin
      if (cfg_idx == REG_DEVICE_ADDRESS) begin
        cfg_r.device_address <= cfg_wdata;
      end
      if (cfg_idx == REG_COMMAND_CONTROL) begin
        cfg_r.command_control <= cfg_wdata;
      end
      if (cfg_idx == REG_DATA_CONTROL) begin
        cfg_r.data_control <= cfg_wdata;
      end
    end
  end

  i2cdfw_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (accept),
    .item  (in_data),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_done |-> out_data.busy_res)
    else $error("frame_done without busy_res");

  a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rejected |-> out_data.busy_res && !out_data.frame_done)
    else $error("rejected item with bad flags");

  a_accept_valid: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted item gave no result");
`endif

endmodule

`default_nettype wire
